[rtl/bitmap_frame_allocator_assert.svh]
// Assertion macros shared by the checker of the bitmap frame allocator.
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// Condition now implies consequence in the same cycle.
`define BFA_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bitmap frame allocator check failed");

// Condition now implies consequence in the next cycle.
`define BFA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bitmap frame allocator check failed");

`endif

[rtl/bfa_pkg.sv]
// Types and constants of the bitmap frame allocator.
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int ROWS       = 8;
    localparam int ROW_BITS   = 64;
    localparam int TOTAL_BITS = ROWS * ROW_BITS;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BIT_W      = $clog2(ROW_BITS);
    localparam int CNT_W      = $clog2(TOTAL_BITS + 1);

    localparam int POS_W      = 9;
    localparam int IDX_W      = 9;
    localparam int COUNT_W    = 10;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_TEST  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_SPACE     = 2'd1,
        ST_ALREADY_FREE = 2'd2
    } status_t;

    typedef struct packed {
        action_t            action;
        logic [POS_W-1:0]   position;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [IDX_W-1:0]   found_index;
        logic               bit_free;
        logic [COUNT_W-1:0] set_count;
    } rsp_t;

    typedef struct packed {
        logic               hit;
        logic [BIT_W-1:0]   bit_idx;
    } find_t;

endpackage

[rtl/bfa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/bfa_find_zero.sv]
// Finds the lowest clear bit of one bitmap row.
`timescale 1ns / 1ps

module bfa_find_zero (
    input  logic [bfa_pkg::ROW_BITS-1:0] row_data,
    output bfa_pkg::find_t               result
);

    import bfa_pkg::*;

    logic [ROW_BITS-1:0] zeros;
    logic [ROW_BITS-1:0] lowest;
    logic [BIT_W-1:0]    idx;

    assign zeros  = ~row_data;
    // Isolate the lowest set bit of the inverted row.
    assign lowest = zeros & (~zeros + ROW_BITS'(1));

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < ROW_BITS; i++)
        begin
            if (lowest[i])
            begin
                idx = idx | BIT_W'(i);
            end
        end
    end

    assign result.hit     = |zeros;
    assign result.bit_idx = idx;

endmodule

[rtl/bitmap_frame_allocator.sv]
// Top level of the bitmap frame allocator: sequencer, row RAM and output register.
`timescale 1ns / 1ps

// The allocation bitmap sits in a RAM of ROWS rows with a registered read. Free is handled as a
// read-modify-write of one row and test as a read of one row: read, modify and write back (free
// only), hand over to the output register; clear only hands over. Allocate reads one row per
// cycle from its start row with wrap-around, at most ROWS rows, and writes back the row in which
// it finds a clear bit. Row valid bits, cleared by reset and by the clear request, make untouched
// rows read as empty, so no clearing pass is needed. A new request is taken only once the
// previous write-back has finished, which keeps reads and writes of the same row apart; a
// finished result may still be waiting in the output register when the next request arrives.
module bitmap_frame_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bfa_pkg::req_t req_item,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bfa_pkg::rsp_t rsp_item
);

    import bfa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    action_t            op_reg, op_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [ROW_W-1:0]   steps_reg, steps_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [ROWS-1:0]    valid_reg, valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    rsp_t               res_reg, res_next;
    rsp_t               out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               accept;
    logic [POS_W-1:0]   hint_q;
    logic [ROW_W-1:0]   hint_row;
    logic [POS_W-1:0]   idx_mod;
    logic [ROW_W-1:0]   acc_row;
    logic [BIT_W-1:0]   acc_bit;
    logic [ROW_W-1:0]   scan_row;

    logic               ram_we;
    logic [ROW_W-1:0]   ram_raddr;
    logic [ROW_BITS-1:0] ram_wdata;
    logic [ROW_BITS-1:0] ram_rdata;
    logic [ROW_BITS-1:0] row_data;
    find_t              find;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    assign hint_q   = req_item.position / POS_W'(ROW_BITS);
    assign hint_row = ROW_W'(hint_q % POS_W'(ROWS));
    assign idx_mod  = POS_W'(32'(req_item.position) % 32'(TOTAL_BITS));
    assign acc_row  = ROW_W'(idx_mod / POS_W'(ROW_BITS));
    assign acc_bit  = BIT_W'(idx_mod % POS_W'(ROW_BITS));

    assign scan_row = (row_reg == ROW_W'(ROWS - 1)) ? '0 : row_reg + 1'b1;

    // While scanning, the next row is requested before the current one has been judged.
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            ram_raddr = (req_item.action == ACT_ALLOC) ? hint_row : acc_row;
        end
        else
        begin
            ram_raddr = scan_row;
        end
    end

    assign row_data = valid_reg[row_reg] ? ram_rdata : '0;

    bfa_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (row_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfa_find_zero u_find (
        .row_data (row_data),
        .result   (find)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        row_next       = row_reg;
        steps_next     = steps_reg;
        bit_next       = bit_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_wdata      = row_data;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req_item.action;
                    steps_next = '0;
                    bit_next   = acc_bit;
                    row_next   = (req_item.action == ACT_ALLOC) ? hint_row : acc_row;
                    res_next   = '{status: ST_OK, found_index: '0, bit_free: 1'b0,
                                   set_count: COUNT_W'(count_reg)};
                    if (req_item.action == ACT_CLEAR)
                    begin
                        valid_next         = '0;
                        count_next         = '0;
                        res_next.set_count = '0;
                        state_next         = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LOOK;
                    end
                end
            end

            S_LOOK:
            begin
                unique case (op_reg)
                    ACT_ALLOC:
                    begin
                        if (find.hit)
                        begin
                            ram_we                = 1'b1;
                            ram_wdata             = row_data | (ROW_BITS'(1) << find.bit_idx);
                            valid_next[row_reg]   = 1'b1;
                            count_next            = count_reg + 1'b1;
                            res_next.found_index  = IDX_W'(32'(row_reg) * 32'(ROW_BITS)
                                                           + 32'(find.bit_idx));
                            res_next.set_count    = COUNT_W'(count_reg + 1'b1);
                            state_next            = S_DONE;
                        end
                        else if (steps_reg == ROW_W'(ROWS - 1))
                        begin
                            res_next.status = ST_NO_SPACE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            row_next   = scan_row;
                            steps_next = steps_reg + 1'b1;
                        end
                    end

                    ACT_FREE:
                    begin
                        if (row_data[bit_reg])
                        begin
                            ram_we              = 1'b1;
                            ram_wdata           = row_data & ~(ROW_BITS'(1) << bit_reg);
                            valid_next[row_reg] = 1'b1;
                            count_next          = count_reg - 1'b1;
                            res_next.set_count  = COUNT_W'(count_reg - 1'b1);
                        end
                        else
                        begin
                            res_next.status = ST_ALREADY_FREE;
                        end
                        state_next = S_DONE;
                    end

                    ACT_TEST:
                    begin
                        res_next.bit_free = !row_data[bit_reg];
                        state_next        = S_DONE;
                    end

                    ACT_CLEAR:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_DONE:
            begin
                // Hand the result over once the output register is free or being emptied.
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= ACT_ALLOC;
            row_reg       <= '0;
            steps_reg     <= '0;
            bit_reg       <= '0;
            valid_reg     <= '0;
            count_reg     <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            row_reg       <= row_next;
            steps_reg     <= steps_next;
            bit_reg       <= bit_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

endmodule

[rtl/bfa_checker.sv]
// Port-level checks of the bitmap frame allocator and their binding to the top level.
`timescale 1ns / 1ps
`include "bitmap_frame_allocator_assert.svh"

module bfa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input bfa_pkg::rsp_t rsp_item
);

    import bfa_pkg::*;

    logic no_space_rsp;
    logic no_space_clean;
    logic test_clean;

    assign no_space_rsp   = rsp_valid && rsp_item.status == ST_NO_SPACE;
    assign no_space_clean = rsp_item.found_index == '0 && !rsp_item.bit_free
                            && rsp_item.set_count == COUNT_W'(TOTAL_BITS);
    assign test_clean     = rsp_item.status == ST_OK && rsp_item.found_index == '0;

    // A stalled result keeps its contents.
    `BFA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

    // The block works on one request at a time, so it is busy after every transfer in.
    `BFA_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && !req_stall, req_stall)

    // A failed allocation only happens on a full bitmap and names no frame.
    `BFA_ASSERT_NOW(a_no_space_full, clk, rst_n, no_space_rsp, no_space_clean)

    // A free bit report comes only from a test, which never fails and allocates nothing.
    `BFA_ASSERT_NOW(a_test_result, clk, rst_n, rsp_valid && rsp_item.bit_free, test_clean)

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (.*);
